[hdl/odas_pkg.sv]
// Shared types and constants of the obstacle avoidance drive sequencer.
package odas_pkg;

  localparam int unsigned DIST_W     = 13;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STEP_W     = 2;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RIGHT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LEFT    = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_STOP_HOLD     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TURN_HOLD     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STUCK_REVERSE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OBST_REVERSE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEAR          = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLEAR         = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE     = 3'd6;

  localparam logic [STEP_W-1:0] STEP_0 = 2'd0;
  localparam logic [STEP_W-1:0] STEP_1 = 2'd1;
  localparam logic [STEP_W-1:0] STEP_2 = 2'd2;
  localparam logic [STEP_W-1:0] STEP_3 = 2'd3;

  typedef enum logic [1:0] {
    SEQ_FORWARD,
    SEQ_OBSTACLE,
    SEQ_STUCK,
    SEQ_TURN
  } seq_e;

  typedef struct packed {
    seq_e seq;
    logic right;
  } seq_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [HOLD_W-1:0] stop_hold;
    logic [HOLD_W-1:0] turn_hold;
    logic [HOLD_W-1:0] stuck_reverse;
    logic [HOLD_W-1:0] obst_reverse;
    logic [DIST_W-1:0] near_thr;
    logic [DIST_W-1:0] clear_thr;
    logic [DIST_W-1:0] tolerance;
  } cfg_t;

endpackage

[hdl/odas_regs.sv]
// Configuration register file behind the APB-style port.
module odas_regs import odas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_hold     <= 16'd200;
      cfg_q.turn_hold     <= 16'd700;
      cfg_q.stuck_reverse <= 16'd1000;
      cfg_q.obst_reverse  <= 16'd500;
      cfg_q.near_thr      <= 13'd320;
      cfg_q.clear_thr     <= 13'd480;
      cfg_q.tolerance     <= 13'd16;
    end else if (wr_en) begin
      case (idx)
        REG_STOP_HOLD:     cfg_q.stop_hold     <= pwdata[HOLD_W-1:0];
        REG_TURN_HOLD:     cfg_q.turn_hold     <= pwdata[HOLD_W-1:0];
        REG_STUCK_REVERSE: cfg_q.stuck_reverse <= pwdata[HOLD_W-1:0];
        REG_OBST_REVERSE:  cfg_q.obst_reverse  <= pwdata[HOLD_W-1:0];
        REG_NEAR:          cfg_q.near_thr      <= pwdata[DIST_W-1:0];
        REG_CLEAR:         cfg_q.clear_thr     <= pwdata[DIST_W-1:0];
        REG_TOLERANCE:     cfg_q.tolerance     <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_STOP_HOLD:     prdata = CFG_DATA_W'(cfg_q.stop_hold);
      REG_TURN_HOLD:     prdata = CFG_DATA_W'(cfg_q.turn_hold);
      REG_STUCK_REVERSE: prdata = CFG_DATA_W'(cfg_q.stuck_reverse);
      REG_OBST_REVERSE:  prdata = CFG_DATA_W'(cfg_q.obst_reverse);
      REG_NEAR:          prdata = CFG_DATA_W'(cfg_q.near_thr);
      REG_CLEAR:         prdata = CFG_DATA_W'(cfg_q.clear_thr);
      REG_TOLERANCE:     prdata = CFG_DATA_W'(cfg_q.tolerance);
      default:           prdata = '0;
    endcase
  end

endmodule

[hdl/odas_fifo.sv]
// Small register queue used between the front, the back and the result ports.
module odas_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/odas_front.sv]
// Front part: sample ring, driving mode and classification of each sample.
module odas_front import odas_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [DIST_W-1:0] distance_i,
  input  cfg_t              cfg_i,
  output logic              cq_push_o,
  output seq_item_t         cq_item_o
);

  localparam int unsigned SW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);

  logic [DIST_W-1:0] ring_q [HISTORY_DEPTH];
  logic [DIST_W-1:0] ring_n [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] close;
  logic [SW-1:0] slot_q;
  logic [FW-1:0] fill_q;
  logic          fwd_q, right_q, force_q;
  logic          stuck, filling, near_hit, clear_hit;

  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      ring_n[i] = (slot_q == SW'(i)) ? distance_i : ring_q[i];
    end
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      logic [DIST_W-1:0] a, b, diff;
      a        = ring_n[i];
      b        = ring_n[(i + 1) % HISTORY_DEPTH];
      diff     = (a > b) ? a - b : b - a;
      close[i] = (diff < cfg_i.tolerance);
    end
  end

  assign stuck     = &close;
  assign filling   = (fill_q < FW'(HISTORY_DEPTH));
  assign near_hit  = (distance_i < cfg_i.near_thr);
  assign clear_hit = (distance_i < cfg_i.clear_thr);

  always_comb begin
    cq_push_o       = 1'b0;
    cq_item_o.seq   = SEQ_FORWARD;
    cq_item_o.right = right_q;
    if (accept_i) begin
      if (filling) begin
        cq_push_o = (fill_q == '0);
      end else if (fwd_q) begin
        if (near_hit) begin
          cq_push_o     = 1'b1;
          cq_item_o.seq = SEQ_OBSTACLE;
        end else if (stuck) begin
          cq_push_o     = 1'b1;
          cq_item_o.seq = SEQ_STUCK;
        end
      end else begin
        cq_push_o     = 1'b1;
        cq_item_o.seq = (clear_hit || force_q) ? SEQ_TURN : SEQ_FORWARD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ring_q[slot_q] <= distance_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      fill_q  <= '0;
      fwd_q   <= 1'b1;
      right_q <= 1'b1;
      force_q <= 1'b0;
    end else if (accept_i) begin
      slot_q <= (slot_q == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      if (filling) begin
        fill_q <= fill_q + 1'b1;
      end else if (fwd_q) begin
        if (near_hit) begin
          fwd_q <= 1'b0;
        end else if (stuck) begin
          fwd_q   <= 1'b0;
          force_q <= 1'b1;
        end
      end else if (clear_hit || force_q) begin
        force_q <= 1'b0;
      end else begin
        fwd_q   <= 1'b1;
        right_q <= !right_q;
      end
    end
  end

endmodule

[hdl/odas_back.sv]
// Back part: expands each queued sequence into motor commands, one per cycle unless rq_full.
module odas_back import odas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_item_t cq_item_i,
  input  logic      cq_empty_i,
  output logic      cq_pop_o,
  input  cfg_t      cfg_i,
  input  logic      rq_full_i,
  output logic      rq_push_o,
  output result_t   rq_item_o
);

  logic [STEP_W-1:0] step_q;
  logic [CMD_W-1:0]  turn_cmd;
  logic              emit;

  assign turn_cmd  = cq_item_i.right ? CMD_RIGHT : CMD_LEFT;
  assign emit      = !cq_empty_i && !rq_full_i;
  assign rq_push_o = emit;
  assign cq_pop_o  = emit && rq_item_o.last;

  always_comb begin
    rq_item_o.cmd  = CMD_STOP;
    rq_item_o.hold = '0;
    rq_item_o.last = 1'b1;
    case (cq_item_i.seq)
      SEQ_OBSTACLE: begin
        case (step_q)
          STEP_0: begin
            rq_item_o.hold = cfg_i.stop_hold;
            rq_item_o.last = 1'b0;
          end
          STEP_1: begin
            rq_item_o.cmd  = CMD_REVERSE;
            rq_item_o.hold = cfg_i.obst_reverse;
            rq_item_o.last = 1'b0;
          end
          STEP_2: begin
            rq_item_o.cmd  = turn_cmd;
            rq_item_o.hold = cfg_i.turn_hold;
            rq_item_o.last = 1'b0;
          end
          default: ;
        endcase
      end
      SEQ_STUCK: begin
        case (step_q)
          STEP_0: begin
            rq_item_o.hold = cfg_i.stop_hold;
            rq_item_o.last = 1'b0;
          end
          default: begin
            rq_item_o.cmd  = CMD_REVERSE;
            rq_item_o.hold = cfg_i.stuck_reverse;
          end
        endcase
      end
      SEQ_TURN: begin
        case (step_q)
          STEP_0: begin
            rq_item_o.hold = cfg_i.stop_hold;
            rq_item_o.last = 1'b0;
          end
          STEP_1: begin
            rq_item_o.cmd  = turn_cmd;
            rq_item_o.hold = cfg_i.turn_hold;
            rq_item_o.last = 1'b0;
          end
          default: ;
        endcase
      end
      default: begin
        rq_item_o.cmd = CMD_FORWARD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_0;
    end else if (emit) begin
      step_q <= rq_item_o.last ? STEP_0 : step_q + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_step_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != STEP_0 |-> !cq_empty_i)
    else $error("sequence step advanced with no queued item");

  a_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emit |=> $stable(step_q))
    else $error("sequence step moved without an emitted command");

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !rq_item_o.last |=> step_q == $past(step_q) + 1'b1)
    else $error("sequence step did not advance after a command");

  a_forward_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cq_empty_i && cq_item_i.seq == SEQ_FORWARD |-> step_q == STEP_0)
    else $error("forward sequence past its only step");

  a_stuck_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cq_empty_i && cq_item_i.seq == SEQ_STUCK |-> step_q == STEP_0 || step_q == STEP_1)
    else $error("stuck sequence past its second step");
`endif

endmodule

[hdl/obstacle_avoid_drive_sequencer.sv]
// Top level of the obstacle avoidance drive sequencer.
//
//   channel   handshake               payload
//   sample    push / full             distance_i
//   command   empty / pop             motor_cmd_o, hold_ms_o, last_o
//   config    psel/penable/pready     paddr, pwdata, pwrite, prdata
//
// A sample is classified in the cycle it is taken; samples arrive back to back while the
// two-entry sequence queue has room. The back issues one command per cycle while the result
// queue has room, and each queued sequence causes one to four commands.
// Reset is asynchronous: registers return to defaults, ring empty, queues empty.
// full rises with the sequence queue; a two-entry result queue lets pop stall freely.
module obstacle_avoid_drive_sequencer import odas_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [DIST_W-1:0]     distance_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [CMD_W-1:0]      motor_cmd_o,
  output logic [HOLD_W-1:0]     hold_ms_o,
  output logic                  last_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  seq_item_t cq_in, cq_out;
  result_t   rq_in, rq_out;
  logic      accept, cq_push, cq_pop, cq_empty;
  logic      rq_push, rq_full;

  assign accept = push && !full;

  odas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  odas_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .distance_i (distance_i),
    .cfg_i      (cfg),
    .cq_push_o  (cq_push),
    .cq_item_o  (cq_in)
  );

  odas_fifo #(
    .WIDTH ($bits(seq_item_t)),
    .DEPTH (2)
  ) u_seq_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_in),
    .full_o  (full),
    .pop_i   (cq_pop),
    .data_o  (cq_out),
    .empty_o (cq_empty)
  );

  odas_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cq_item_i  (cq_out),
    .cq_empty_i (cq_empty),
    .cq_pop_o   (cq_pop),
    .cfg_i      (cfg),
    .rq_full_i  (rq_full),
    .rq_push_o  (rq_push),
    .rq_item_o  (rq_in)
  );

  odas_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_out),
    .empty_o (empty)
  );

  assign motor_cmd_o = rq_out.cmd;
  assign hold_ms_o   = rq_out.hold;
  assign last_o      = rq_out.last;

endmodule
